@@ rtl/hme_pkg.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine package
// Shared constants, codes, types and helpers of the hash multiset engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hme_pkg;

  localparam int KeyW           = 32;
  localparam int OpW            = 2;
  localparam int StatusW        = 2;
  localparam int CfgW           = 7;
  localparam int MaxBuckets     = 64;
  localparam int SlotsPerBucket = 8;
  localparam int StoreDepth     = MaxBuckets * SlotsPerBucket;

  localparam int BucketW        = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int FillW          = $clog2(SlotsPerBucket + 1);
  localparam int StoreAddrW     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CntW           = $clog2(KeyW);
  localparam int DivW           = (CfgW > BucketW + 1) ? CfgW : BucketW + 1;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(MaxBuckets);

  localparam int QueueDepth     = 2;
  localparam int QPtrW          = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW          = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_FILL,
    BE_RD,
    BE_CMP,
    BE_MOVE
  } be_state_e;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [KeyW-1:0]    key;
    logic [BucketW-1:0] bucket;
  } hme_cmd_t;

  // Handshake between the command queue and one of its sides.
  typedef struct packed {
    logic xfer;
  } hme_qctl_t;

  // Store address of slot idx in bucket b.
  function automatic logic [StoreAddrW-1:0] slot_addr(logic [BucketW-1:0] b,
                                                      logic [FillW-1:0]   idx);
    logic [StoreAddrW-1:0] base;
    base = StoreAddrW'(b) * StoreAddrW'(SlotsPerBucket);
    return base + StoreAddrW'(idx);
  endfunction

endpackage

`default_nettype wire

@@ rtl/hme_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hme_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/hme_front.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine front end
// Accepts requests and works out the bucket with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hme_front
  import hme_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [OpW-1:0]  operation_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [CfgW-1:0] bucket_count_i,
  output hme_qctl_t            q_ctl_o,
  input  wire logic            q_full_i,
  output hme_cmd_t             q_cmd_o
);

  fe_state_e          state_q, state_d;
  logic [OpW-1:0]     op_q, op_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [BucketW-1:0] rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [DivW-1:0]    div_n;
  logic [DivW-1:0]    trial;
  logic [BucketW-1:0] rem_step;

  // Divisor with the out-of-range counts folded back into 1..MaxBuckets.
  always_comb begin
    if (bucket_count_i == '0) begin
      div_n = DivW'(1);
    end else if (DivW'(bucket_count_i) > DivW'(MaxBuckets)) begin
      div_n = DivW'(MaxBuckets);
    end else begin
      div_n = DivW'(bucket_count_i);
    end
  end

  // One restoring step: bring down the next key bit, subtract if it fits.
  always_comb begin
    trial = DivW'({rem_q, key_q[cnt_q]});
    if (trial >= div_n) begin
      rem_step = BucketW'(trial - div_n);
    end else begin
      rem_step = BucketW'(trial);
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    q_ctl_o.xfer = 1'b0;
    full         = 1'b1;
    case (state_q)
      FE_IDLE: begin
        full = 1'b0;
        if (push) begin
          op_d    = operation_i;
          key_d   = key_i;
          rem_d   = '0;
          cnt_d   = CntW'(KeyW - 1);
          state_d = FE_DIV;
        end
      end
      FE_DIV: begin
        rem_d = rem_step;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!q_full_i) begin
          q_ctl_o.xfer = 1'b1;
          state_d      = FE_IDLE;
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  assign q_cmd_o.op     = op_q;
  assign q_cmd_o.key    = key_q;
  assign q_cmd_o.bucket = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  // The remainder stays below the divisor throughout the division.
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FE_DIV) |-> (DivW'(rem_q) < div_n))
    else $error("front: partial remainder not below divisor");

  // An accepted request is ready for the queue once the division has handled every key bit.
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ##(KeyW + 1) (state_q == FE_PUSH))
    else $error("front: division did not finish on time");

endmodule

`default_nettype wire

@@ rtl/hme_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine command queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hme_cmd_fifo
  import hme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire hme_qctl_t wr_ctl_i,
  input  wire hme_cmd_t  cmd_i,
  output logic           full_o,
  input  wire hme_qctl_t rd_ctl_i,
  output hme_cmd_t       cmd_o,
  output logic           empty_o
);

  hme_cmd_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_ctl_i.xfer && !full_o;
  assign do_rd   = rd_ctl_i.xfer && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] p);
    if (p == QPtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_rd) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hme_back.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine back end
// Carries out insert, remove and lookup on the bucket store, one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module hme_back
  import hme_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire hme_cmd_t         q_cmd_i,
  output hme_qctl_t             q_ctl_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [StatusW-1:0]    status_o
);

  be_state_e        state_q, state_d;
  hme_cmd_t         cmd_q, cmd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] idx_q, idx_d;
  logic [FillW-1:0] last;
  logic             res_valid_q;
  status_e          res_status_q, res_status;
  logic             res_load;

  logic [MaxBuckets-1:0] fill_vld_q;
  logic                  fram_we;
  logic [BucketW-1:0]    fram_raddr;
  logic [FillW-1:0]      fram_wdata, fram_rdata;
  logic [FillW-1:0]      fill_raw, fill_eff;

  logic                  sram_we;
  logic [StoreAddrW-1:0] sram_waddr, sram_raddr;
  logic [KeyW-1:0]       sram_wdata, sram_rdata;

  hme_ram #(
    .Width(FillW),
    .Depth(MaxBuckets)
  ) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fram_we),
    .waddr_i(cmd_q.bucket),
    .wdata_i(fram_wdata),
    .raddr_i(fram_raddr),
    .rdata_o(fram_rdata)
  );

  hme_ram #(
    .Width(KeyW),
    .Depth(StoreDepth)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (sram_we),
    .waddr_i(sram_waddr),
    .wdata_i(sram_wdata),
    .raddr_i(sram_raddr),
    .rdata_o(sram_rdata)
  );

  // A bucket never written since reset reads as empty.
  assign fill_raw   = fill_vld_q[cmd_q.bucket] ? fram_rdata : '0;
  assign fill_eff   = (fill_raw > FillW'(SlotsPerBucket)) ? FillW'(SlotsPerBucket) : fill_raw;
  assign fram_raddr = (state_q == BE_IDLE) ? q_cmd_i.bucket : cmd_q.bucket;
  assign last       = fill_q - FillW'(1);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    q_ctl_o.xfer = 1'b0;
    fram_we      = 1'b0;
    fram_wdata   = fill_q;
    sram_we      = 1'b0;
    sram_waddr   = slot_addr(cmd_q.bucket, idx_q);
    sram_wdata   = cmd_q.key;
    sram_raddr   = slot_addr(cmd_q.bucket, idx_q);
    res_load     = 1'b0;
    res_status   = STATUS_OK;
    case (state_q)
      BE_IDLE: begin
        if (!q_empty_i && (!res_valid_q || pop)) begin
          q_ctl_o.xfer = 1'b1;
          cmd_d        = q_cmd_i;
          state_d      = BE_FILL;
        end
      end
      BE_FILL: begin
        fill_d = fill_eff;
        idx_d  = '0;
        if (cmd_q.op == OP_INSERT) begin
          res_load = 1'b1;
          state_d  = BE_IDLE;
          if (fill_eff >= FillW'(SlotsPerBucket)) begin
            res_status = STATUS_FULL;
          end else begin
            sram_we    = 1'b1;
            sram_waddr = slot_addr(cmd_q.bucket, fill_eff);
            fram_we    = 1'b1;
            fram_wdata = fill_eff + FillW'(1);
          end
        end else if (fill_eff == '0) begin
          res_load   = 1'b1;
          res_status = STATUS_ABSENT;
          state_d    = BE_IDLE;
        end else begin
          state_d = BE_RD;
        end
      end
      BE_RD: begin
        state_d = BE_CMP;
      end
      BE_CMP: begin
        // Fetch the last slot now in case a removal has to move it.
        sram_raddr = slot_addr(cmd_q.bucket, last);
        if (sram_rdata == cmd_q.key) begin
          if ((cmd_q.op == OP_REMOVE) && (idx_q != last)) begin
            state_d = BE_MOVE;
          end else begin
            if (cmd_q.op == OP_REMOVE) begin
              fram_we    = 1'b1;
              fram_wdata = last;
            end
            res_load = 1'b1;
            state_d  = BE_IDLE;
          end
        end else if (idx_q == last) begin
          res_load   = 1'b1;
          res_status = STATUS_ABSENT;
          state_d    = BE_IDLE;
        end else begin
          idx_d   = idx_q + FillW'(1);
          state_d = BE_RD;
        end
      end
      BE_MOVE: begin
        sram_we    = 1'b1;
        sram_wdata = sram_rdata;
        fram_we    = 1'b1;
        fram_wdata = last;
        res_load   = 1'b1;
        state_d    = BE_IDLE;
      end
      default: begin
        state_d = BE_IDLE;
      end
    endcase
  end

  assign empty    = !res_valid_q;
  assign status_o = res_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      res_valid_q <= 1'b0;
      fill_vld_q  <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
      if (fram_we) begin
        fill_vld_q[cmd_q.bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    fill_q <= fill_d;
    idx_q  <= idx_d;
    if (res_load) begin
      res_status_q <= res_status;
    end
  end

  // A finished request always finds the result register free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !res_valid_q)
    else $error("back: result register overwritten");

  // A bucket never holds more keys than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_FILL) |-> (fill_raw <= FillW'(SlotsPerBucket)))
    else $error("back: bucket fill count out of range");

endmodule

`default_nettype wire

@@ rtl/hash_multiset_engine_top.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine
// Hashed multiset of 32-bit keys with bounded buckets: insert, remove, lookup.
// ----------------------------------------------------------------------------
// Every request on push carries an operation and a key and produces exactly
// one status on the result side, in request order: done or found, key not
// present, or bucket full on insert. The bucket is the key modulo the bucket
// count register, where a count of zero acts as one and a count above the
// number of buckets acts as the full number. Each bucket holds up to eight
// keys, duplicates included; changing the bucket count while keys are held
// leaves them where they are, so they may then be reported as absent. The
// front end takes one request at a time: it accepts the request, finds the
// remainder with a restoring divider that handles one key bit per cycle and
// then hands the request on to the command queue. The back end then reads the
// fill count and scans the bucket's slots one at a time, as the slot store has
// a single registered read port. A two-entry command queue and the result
// register sit between the parts, so requests keep being accepted while a
// status waits to be popped. The stored keys are not cleared at reset;
// per-bucket valid flags make every bucket read as empty after reset, so the
// block is ready immediately. The bucket count is to be written only while
// no request is outstanding; cfg_ready_o is always high.
`default_nettype none

module hash_multiset_engine_top
  import hme_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [OpW-1:0]     operation_i,
  input  wire logic [KeyW-1:0]    key_i,
  // Result side
  output logic                    empty,
  input  wire logic               pop,
  output logic      [StatusW-1:0] status_o,
  // Configuration write channel: bucket count
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [CfgW-1:0] bucket_count_q;

  hme_qctl_t fe_qctl, be_qctl;
  hme_cmd_t  fe_cmd, be_cmd;
  logic      q_full, q_empty;

  // The bucket count register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  // Front end: accepts the request and finds its bucket.
  hme_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .bucket_count_i(bucket_count_q),
    .q_ctl_o       (fe_qctl),
    .q_full_i      (q_full),
    .q_cmd_o       (fe_cmd)
  );

  // Queue of classified requests, so that each side can stall on its own.
  hme_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_ctl_i(fe_qctl),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .rd_ctl_i(be_qctl),
    .cmd_o   (be_cmd),
    .empty_o (q_empty)
  );

  // Back end: works on the bucket store and holds the status until popped.
  hme_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_cmd_i  (be_cmd),
    .q_ctl_o  (be_qctl),
    .empty    (empty),
    .pop      (pop),
    .status_o (status_o)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Hash multiset engine testbench
// Checks insert, remove and lookup statuses against a predictor of the store.
// ----------------------------------------------------------------------------
// Requests wait in a backlog until the request driver puts them on the push
// side. The driver sends in bursts of random length with random gaps between
// them. When the block accepts a request, the driver runs it through a
// predictor that keeps its own copy of the buckets and of the bucket count.
// The predictor's status joins a queue of statuses still due. On the pop side,
// the result monitor stalls on a pattern of its own and compares each status
// it takes with the oldest one due.
// The stimulus starts with a short directed run over the corner cases. This
// is followed by random phases, each with its own bucket count. Between
// phases the sender drains the block completely before the register is
// written.
`timescale 1ns / 1ps

module tb;
  import hme_pkg::*;

  // Operation code 3 is not part of the enum; the block treats it as a lookup.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam int ResetCycles = 4;
  localparam int PoolSize    = 16;
  localparam int PhaseItems  = 88;
  localparam int HoldCycles  = 400;
  // Front end division plus a full bucket scan, rounded up generously.
  localparam int SettleCycles = 64;
  localparam int IdleLimit    = 5000;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
  } hash_req_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  logic [OpW-1:0]     operation_i = '0;
  logic [KeyW-1:0]    key_i       = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [StatusW-1:0] status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  hash_multiset_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .key_i       (key_i),
    .empty       (empty),
    .pop         (pop),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the keys held in each bucket, the fill count of each
  // bucket and the bucket count register as last written.
  logic [KeyW-1:0] model_keys [MaxBuckets][SlotsPerBucket];
  int              model_fill [MaxBuckets] = '{default: 0};
  logic [CfgW-1:0] model_count = CfgReset;

  hash_req_t       req_backlog [$];
  status_e         status_due  [$];
  logic [KeyW-1:0] key_pool    [PoolSize];

  int error_count = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int hold_left   = 0;
  int mode_left   = 0;
  int pop_pct     = 100;
  int idle_cycles = 0;
  bit hold_go     = 1'b0;
  bit hold_seen   = 1'b0;

  // Applies one request to the predictor state and returns its status. A
  // count of zero acts as one bucket and a count above the store acts as the
  // whole store. Keys already held stay in their buckets when the count
  // changes.
  function automatic status_e predict_status(input logic [OpW-1:0] op,
                                             input logic [KeyW-1:0] key);
    logic [KeyW-1:0] span;
    int              b;
    int              f;
    int              pos;
    status_e         st;
    span = KeyW'(model_count);
    if (span == 0) span = 1;
    if (span > MaxBuckets) span = MaxBuckets;
    b   = int'(key % span);
    f   = model_fill[b];
    pos = -1;
    for (int i = 0; i < f; i++) begin
      if (pos < 0 && model_keys[b][i] == key) pos = i;
    end
    case (op)
      OP_INSERT: begin
        if (f >= SlotsPerBucket) begin
          st = STATUS_FULL;
        end else begin
          model_keys[b][f] = key;
          model_fill[b]    = f + 1;
          st               = STATUS_OK;
        end
      end
      OP_REMOVE: begin
        if (pos < 0) begin
          st = STATUS_ABSENT;
        end else begin
          // The last held key moves into the hole.
          model_keys[b][pos] = model_keys[b][f-1];
          model_fill[b]      = f - 1;
          st                 = STATUS_OK;
        end
      end
      default: st = (pos < 0) ? STATUS_ABSENT : STATUS_OK;
    endcase
    return st;
  endfunction

  // Keys mostly come from a small pool, so that duplicates, hits on remove
  // and full buckets are common. The rest are extremes or fully random keys.
  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 65) return key_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 75) return OP_REMOVE;
    if (r < 97) return OP_LOOKUP;
    return OP_UNUSED;
  endfunction

  task automatic queue_req(input logic [OpW-1:0] op, input logic [KeyW-1:0] key);
    hash_req_t req;
    req.op  = op;
    req.key = key;
    req_backlog.push_back(req);
  endtask

  // Waits on falling edges, clear of the driver and monitor, until no request
  // is pending or in flight, then lets the given number of cycles pass.
  task automatic wait_drained(input int margin);
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || push || status_due.size() != 0);
    repeat (margin) @(negedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CfgW-1:0] value);
    wait_drained(4);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    model_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver. A request stays on the port until the block takes it.
  // After each burst, a gap of random length follows. Half of the gaps are
  // zero, which leaves stretches without idling.
  always @(posedge clk_i) begin : req_driver
    hash_req_t next_req;
    bit        took;
    took = 1'b0;
    if (rst_ni && push && !full) begin
      status_due.push_back(predict_status(operation_i, key_i));
      if (burst_left > 0) burst_left--;
      took = 1'b1;
    end
    if (!push || took) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 90);
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (rst_ni && req_backlog.size() != 0) begin
        next_req     = req_backlog.pop_front();
        push        <= 1'b1;
        operation_i <= next_req.op;
        key_i       <= next_req.key;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor. The pop rate changes between segments of random length.
  // One long hold-off is inserted once the stimulus asks for it, so that the
  // block backs up and raises full.
  always @(posedge clk_i) begin : result_monitor
    status_e want;
    if (rst_ni && pop && !empty) begin
      if (status_due.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("unexpected status %0d with no request outstanding", status_o);
      end else begin
        want = status_due.pop_front();
        if (status_o !== want) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("status mismatch: expected %0d, got %0d", want, status_o);
        end
      end
    end
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 300);
      case ($urandom_range(0, 3))
        0:       pop_pct = 100;
        1:       pop_pct = 60;
        2:       pop_pct = 25;
        default: pop_pct = 5;
      endcase
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(1, 100) <= pop_pct);
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CfgW-1:0] phase_counts [8];
    phase_counts = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd1, 7'd8, 7'd100};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed run at the reset count of 64 buckets.
    queue_req(OP_LOOKUP, 32'h0);           // empty store
    queue_req(OP_REMOVE, 32'hFFFF_FFFF);   // remove of an absent key
    queue_req(OP_INSERT, 32'h0);
    queue_req(OP_INSERT, 32'h0);           // duplicate copy
    queue_req(OP_REMOVE, 32'h0);
    queue_req(OP_UNUSED, 32'h0);           // unused code acts as a lookup
    queue_req(OP_REMOVE, 32'h0);
    queue_req(OP_REMOVE, 32'h0);           // no copy left
    // Fill bucket 63 to the brim, then overflow it.
    queue_req(OP_INSERT, 32'hFFFF_FFFF);
    for (int i = 0; i < SlotsPerBucket - 1; i++)
      queue_req(OP_INSERT, 32'd63 + 32'd64 * i);
    queue_req(OP_INSERT, 32'h8000_003F);   // bucket full
    queue_req(OP_REMOVE, 32'd127);         // hole filled by the last key
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 32'd127);
    queue_req(OP_INSERT, 32'd127);

    // A count of zero acts as one bucket: bucket 63's keys are no longer seen.
    write_bucket_count(7'd0);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF);
    queue_req(OP_INSERT, 32'h5555_5555);
    queue_req(OP_LOOKUP, 32'h5555_5555);
    // A count above the store acts as the whole store: bucket 63 is back.
    write_bucket_count(7'd127);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF);

    // Random phases. One phase is written as a random count in range.
    phase_counts[5] = CfgW'($urandom_range(1, MaxBuckets));
    for (int ph = 0; ph < 8; ph++) begin
      write_bucket_count(phase_counts[ph]);
      for (int i = 0; i < PoolSize; i++) begin
        if ($urandom_range(0, 1))
          key_pool[i] = ($urandom() & ~32'h3F) | KeyW'($urandom_range(0, 3));
        else
          key_pool[i] = $urandom();
      end
      if (ph == 1) hold_go = 1'b1;
      for (int i = 0; i < PhaseItems; i++)
        queue_req(pick_op(), pick_key());
    end

    wait_drained(SettleCycles);
    if (status_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
